// ===== hw/rtl/bdq_pkg.sv =====
// Package for the bounded double-ended queue: request and status codes,
// the store depth and the command struct broadcast along the cell row.
// No dependencies.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int unsigned DEPTH   = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_PUSH_REAR  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_REAR   = 2'd2,
    REQ_POP_FRONT  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef logic signed [WORD_W-1:0] word_t;

  // Command seen by every cell in the cycle a request is applied, with the
  // pushed word so that the tail cell can take it directly.
  typedef struct packed {
    logic  en;
    req_e  op;
    word_t data;
  } cmd_t;

endpackage

// ===== hw/rtl/bdq_cell.sv =====
// One storage cell of the queue row: a word and an occupied flag.
// Shifts with its neighbours on front requests, fills or drains at the tail.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bdq_pkg::cmd_t  cmd_i,
  input  logic           left_valid_i,
  input  bdq_pkg::word_t left_data_i,
  input  logic           right_valid_i,
  input  bdq_pkg::word_t right_data_i,
  output logic           valid_o,
  output bdq_pkg::word_t data_o,
  output bdq_pkg::word_t tail_data_o
);
  import bdq_pkg::*;

  logic  valid_q, valid_d;
  word_t data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (cmd_i.en) begin
      unique case (cmd_i.op)
        REQ_PUSH_REAR: begin
          // first free cell behind an occupied one takes the beat
          if (!valid_q && left_valid_i) begin
            valid_d = 1'b1;
            data_d  = cmd_i.data;
          end
        end
        REQ_PUSH_FRONT: begin
          valid_d = left_valid_i;
          data_d  = left_data_i;
        end
        REQ_POP_REAR: begin
          if (valid_q && !right_valid_i) begin
            valid_d = 1'b0;
          end
        end
        REQ_POP_FRONT: begin
          valid_d = right_valid_i;
          data_d  = right_data_i;
        end
        default: begin
          valid_d = valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o     = valid_q;
  assign data_o      = data_q;
  assign tail_data_o = (valid_q && !right_valid_i) ? data_q : '0;

endmodule

// ===== hw/rtl/bounded_double_ended_queue_top.sv =====
// Top level of the bounded double-ended queue: a row of DEPTH cells kept
// packed from the front, a word counter and a result register.
// Depends on bdq_pkg and bdq_cell.
//
//   channel | direction | handshake             | payload
//   in      | sink      | in_valid_i/in_stall_o | req_type_i, push_value_i
//   out     | source    | out_valid_o/out_stall_i | status_o, popped_value_o,
//           |           |                       | count_o, front_value_o, rear_value_o
//
// One request is taken per cycle while the output is not stalled; its result is
// registered and shows in the next cycle. The cell row shifts as a whole on
// front pushes and pops, so front requests take no longer than rear ones.
// Reset empties the row and clears the counter, result valid and status; the popped word is not reset.
// A stalled result holds the row, and the input is stalled until it is taken.
`timescale 1ns / 1ps

module bounded_double_ended_queue_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bdq_pkg::req_e                  req_type_i,
  input  bdq_pkg::word_t                 push_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bdq_pkg::status_e               status_o,
  output bdq_pkg::word_t                 popped_value_o,
  output logic [bdq_pkg::COUNT_W-1:0]    count_o,
  output bdq_pkg::word_t                 front_value_o,
  output bdq_pkg::word_t                 rear_value_o
);
  import bdq_pkg::*;

  logic  cell_valid [DEPTH];
  word_t cell_data  [DEPTH];
  word_t cell_tail  [DEPTH];
  logic  left_valid [DEPTH];
  word_t left_data  [DEPTH];
  logic  right_valid[DEPTH];
  word_t right_data [DEPTH];

  logic                out_valid_q;
  status_e             status_q, status_d;
  word_t               popped_q, popped_d;
  logic [COUNT_W-1:0]  count_q, count_d;

  logic  accept;
  logic  is_full, is_empty, is_push, req_ok;
  word_t rear_word;
  cmd_t  cmd;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_full  = cell_valid[DEPTH-1];
  assign is_empty = !cell_valid[0];
  assign is_push  = (req_type_i == REQ_PUSH_REAR) || (req_type_i == REQ_PUSH_FRONT);
  assign req_ok   = is_push ? !is_full : !is_empty;

  assign cmd = '{en: accept && req_ok, op: req_type_i, data: push_value_i};

  // rear word: only the tail cell drives a non-zero word
  always_comb begin
    rear_word = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | cell_tail[i];
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_valid[i] = 1'b1;
      assign left_data[i]  = push_value_i;
    end else begin : g_body
      assign left_valid[i] = cell_valid[i-1];
      assign left_data[i]  = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_valid[i] = 1'b0;
      assign right_data[i]  = '0;
    end else begin : g_inner
      assign right_valid[i] = cell_valid[i+1];
      assign right_data[i]  = cell_data[i+1];
    end

    bdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_valid_i (left_valid[i]),
      .left_data_i  (left_data[i]),
      .right_valid_i(right_valid[i]),
      .right_data_i (right_data[i]),
      .valid_o      (cell_valid[i]),
      .data_o       (cell_data[i]),
      .tail_data_o  (cell_tail[i])
    );
  end

  always_comb begin
    status_d = ST_DONE;
    popped_d = '0;
    count_d  = count_q;
    if (!req_ok) begin
      status_d = is_push ? ST_FULL : ST_EMPTY;
    end else if (is_push) begin
      count_d = count_q + COUNT_W'(1);
    end else begin
      count_d  = count_q - COUNT_W'(1);
      popped_d = (req_type_i == REQ_POP_FRONT) ? cell_data[0] : rear_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      status_q    <= ST_DONE;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
        status_q    <= status_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
    end
  end

  // row and counter only move on an accepted beat, so these hold while stalled
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign count_o        = count_q;
  assign front_value_o  = cell_valid[0] ? cell_data[0] : '0;
  assign rear_value_o   = rear_word;

endmodule

// ===== dv/bounded_double_ended_queue_top_tb.sv =====
// Self-checking testbench for bounded_double_ended_queue_top: drives requests with
// random idling and output stalls, predicts every result and compares each field.
// Depends on bdq_pkg and the RTL of the queue.
`timescale 1ns / 1ps

module bounded_double_ended_queue_top_tb;
  import bdq_pkg::*;

  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned IDLE_PCT     = 17;

  typedef struct {
    status_e              status;
    word_t                popped;
    logic [COUNT_W-1:0]   count;
    word_t                front;
    word_t                rear;
  } deque_reply_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  req_e                 req_type_i;
  word_t                push_value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  status_e              status_o;
  word_t                popped_value_o;
  logic [COUNT_W-1:0]   count_o;
  word_t                front_value_o;
  word_t                rear_value_o;

  // Shadow copy of the queue contents
  word_t                shadow_words [DEPTH];
  int unsigned          shadow_head;
  int unsigned          shadow_count;

  deque_reply_t         predicted_replies[$];
  deque_reply_t         oldest_reply;
  bit                   calm;
  int unsigned          mismatches;
  int unsigned          cycle_cnt;
  int unsigned          n_push_ok, n_pop_ok, n_full_rejects, n_empty_rejects, n_full_hits;

  bounded_double_ended_queue_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .count_o        (count_o),
    .front_value_o  (front_value_o),
    .rear_value_o   (rear_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2.0) clk_i = ~clk_i;
  end

  // Apply one request to the shadow queue and return the reply it should cause.
  function automatic deque_reply_t deque_apply(req_e op, word_t val);
    deque_reply_t r;
    r.status = ST_DONE;
    r.popped = '0;
    case (op)
      REQ_PUSH_REAR: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[(shadow_head + shadow_count) % DEPTH] = val;
          shadow_count++;
        end
      end
      REQ_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_words[shadow_head] = val;
          shadow_count++;
        end
      end
      REQ_POP_REAR: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = shadow_words[(shadow_head + shadow_count - 1) % DEPTH];
          shadow_count--;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = shadow_words[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
    endcase
    r.count = shadow_count[COUNT_W-1:0];
    r.front = '0;
    r.rear  = '0;
    if (shadow_count != 0) begin
      r.front = shadow_words[shadow_head];
      r.rear  = shadow_words[(shadow_head + shadow_count - 1) % DEPTH];
    end
    return r;
  endfunction

  // Record accepted requests first, then check accepted results, in one process.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predicted_replies.push_back(deque_apply(req_type_i, push_value_i));
        case (predicted_replies[$].status)
          ST_FULL:  n_full_rejects++;
          ST_EMPTY: n_empty_rejects++;
          default: begin
            if (req_type_i == REQ_PUSH_REAR || req_type_i == REQ_PUSH_FRONT) n_push_ok++;
            else n_pop_ok++;
          end
        endcase
        if (shadow_count == DEPTH) n_full_hits++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (predicted_replies.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatches++;
        end else begin
          oldest_reply = predicted_replies.pop_front();
          if (status_o !== oldest_reply.status) begin
            $error("status: expected %0d, got %0d", oldest_reply.status, status_o);
            mismatches++;
          end
          if (popped_value_o !== oldest_reply.popped) begin
            $error("popped_value: expected %0d, got %0d", oldest_reply.popped, popped_value_o);
            mismatches++;
          end
          if (count_o !== oldest_reply.count) begin
            $error("count: expected %0d, got %0d", oldest_reply.count, count_o);
            mismatches++;
          end
          if (front_value_o !== oldest_reply.front) begin
            $error("front_value: expected %0d, got %0d", oldest_reply.front, front_value_o);
            mismatches++;
          end
          if (rear_value_o !== oldest_reply.rear) begin
            $error("rear_value: expected %0d, got %0d", oldest_reply.rear, rear_value_o);
            mismatches++;
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one request beat; called and returning on a falling edge.
  task automatic send_req(req_e op, word_t val);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    req_type_i   = op;
    push_value_i = val;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Hold off new requests until every outstanding result has been taken.
  task automatic wait_results_drained();
    in_valid_i = 1'b0;
    while (predicted_replies.size() != 0) @(negedge clk_i);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(9))
      0:       return word_t'(32'h8000_0000);
      1:       return word_t'(32'h7fff_ffff);
      2:       return '0;
      3:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic req_e pick_op(int unsigned push_pct);
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
    return $urandom_range(1) ? REQ_POP_REAR : REQ_POP_FRONT;
  endfunction

  // Pops on an empty queue, with extreme values on the ignored word.
  task automatic test_empty_pops();
    send_req(REQ_POP_REAR, word_t'(32'h7fff_ffff));
    send_req(REQ_POP_FRONT, word_t'(32'h8000_0000));
  endtask

  // Fill from both ends with extreme words, push into a full queue, then drain
  // from both ends and pop once more past empty.
  task automatic test_fill_overflow_drain();
    send_req(REQ_PUSH_REAR, word_t'(32'h8000_0000));
    send_req(REQ_PUSH_FRONT, word_t'(32'h7fff_ffff));
    send_req(REQ_PUSH_REAR, '0);
    send_req(REQ_PUSH_FRONT, '1);
    send_req(REQ_PUSH_REAR, word_t'(32'h5555_5555));
    send_req(REQ_PUSH_FRONT, word_t'(32'haaaa_aaaa));
    send_req(REQ_PUSH_REAR, word_t'(32'h0000_0001));
    send_req(REQ_PUSH_FRONT, word_t'(32'hffff_fffe));
    send_req(REQ_PUSH_REAR, word_t'(32'h1234_5678));
    send_req(REQ_PUSH_FRONT, word_t'(32'h8765_4321));
    for (int i = 0; i < DEPTH; i++) send_req(i[0] ? REQ_POP_REAR : REQ_POP_FRONT, '1);
    send_req(REQ_POP_REAR, '0);
  endtask

  // A single word is both front and rear.
  task automatic test_single_word();
    send_req(REQ_PUSH_FRONT, word_t'(32'hdead_beef));
    send_req(REQ_POP_REAR, '0);
    send_req(REQ_PUSH_REAR, word_t'(32'h0bad_f00d));
    send_req(REQ_POP_FRONT, '0);
  endtask

  // Phases that lean towards filling, draining or neither, so the count walks
  // across its whole range; one phase runs without idling or stalls, some end drained.
  task automatic test_random_walk(int unsigned n_items);
    int unsigned sent;
    int unsigned phase_no;
    int unsigned phase_len;
    int unsigned push_pct;
    sent     = 0;
    phase_no = 0;
    while (sent < n_items) begin
      phase_len = (phase_no == 3) ? 200 : $urandom_range(12, 60);
      case ($urandom_range(2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      calm = (phase_no == 3);
      for (int i = 0; i < phase_len && sent < n_items; i++) begin
        send_req(pick_op(push_pct), pick_word());
        sent++;
      end
      calm = 1'b0;
      if (phase_no % 5 == 4) wait_results_drained();
      phase_no++;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_PUSH_REAR;
    push_value_i = '0;
    out_stall_i  = 1'b0;
    calm         = 1'b0;
    mismatches   = 0;
    cycle_cnt    = 0;
    n_push_ok = 0; n_pop_ok = 0; n_full_rejects = 0; n_empty_rejects = 0; n_full_hits = 0;
    shadow_head  = 0;
    shadow_count = 0;
    foreach (shadow_words[i]) shadow_words[i] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_pops();
    test_fill_overflow_drain();
    test_single_word();
    wait_results_drained();
    test_random_walk(RANDOM_ITEMS);

    wait_results_drained();
    repeat (8) @(negedge clk_i);
    $display("Covered %0d accepted pushes, %0d accepted pops, %0d full rejects, %0d empty rejects,",
             n_push_ok, n_pop_ok, n_full_rejects, n_empty_rejects);
    $display("queue full after %0d requests; %0d field mismatches.", n_full_hits, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_cell.sv
hw/rtl/bounded_double_ended_queue_top.sv
dv/bounded_double_ended_queue_top_tb.sv
